/* src/ppmp6_pkg.sv */
// Shared types and constants for the PPM P6 stream parser.
`timescale 1ns / 1ps
package ppmp6_pkg;

  // Byte plus its character class, as passed from the front end to the parser.
  typedef struct packed {
    logic [7:0] data;
    logic [3:0] digit;
    logic       is_ws;
    logic       is_digit;
    logic       is_hash;
    logic       is_p;
    logic       is_six;
    logic       is_eol;
  } ppmp6_beat_t;

  // Handshake between queue and parser.
  typedef struct packed {
    logic        valid;
    ppmp6_beat_t beat;
  } ppmp6_qout_t;

  localparam int unsigned QDEPTH = 2;
  localparam int unsigned QPTR_W = $clog2(QDEPTH);
  localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

  localparam logic [1:0] KIND_HEADER = 2'd0;
  localparam logic [1:0] KIND_PIXEL  = 2'd1;
  localparam logic [1:0] KIND_ERROR  = 2'd2;

  localparam logic [1:0] FAULT_MAGIC    = 2'd0;
  localparam logic [1:0] FAULT_MAXVAL   = 2'd1;
  localparam logic [1:0] FAULT_NONDIGIT = 2'd2;
  localparam logic [1:0] FAULT_OVERFLOW = 2'd3;

  localparam logic [15:0] MAXVAL_REQ = 16'd255;

endpackage

/* src/ppmp6_front.sv */
// Front end: classifies each incoming byte for the parser.
`timescale 1ns / 1ps
module ppmp6_front
  import ppmp6_pkg::*;
(
  input  logic [7:0]  in_data_byte,
  output ppmp6_beat_t beat
);

  always_comb begin
    beat.data     = in_data_byte;
    beat.digit    = in_data_byte[3:0];
    beat.is_ws    = (in_data_byte == 8'h20) ||
                    ((in_data_byte >= 8'h09) && (in_data_byte <= 8'h0D));
    beat.is_digit = (in_data_byte >= 8'h30) && (in_data_byte <= 8'h39);
    beat.is_hash  = (in_data_byte == 8'h23);
    beat.is_p     = (in_data_byte == 8'h50) || (in_data_byte == 8'h70);
    beat.is_six   = (in_data_byte == 8'h36);
    beat.is_eol   = (in_data_byte == 8'h0A) || (in_data_byte == 8'h0D);
  end

endmodule

/* src/ppmp6_queue.sv */
// Short FIFO decoupling the byte classifier from the parser.
`timescale 1ns / 1ps
module ppmp6_queue
  import ppmp6_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push_valid,
  output logic              push_ready,
  input  ppmp6_beat_t       push_beat,
  output ppmp6_qout_t       head,
  input  logic              pop_ready,
  output logic [QCNT_W-1:0] fill
);

  ppmp6_beat_t       mem_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] count_r, count_nxt;
  logic              push, pop;

  assign push_ready = (count_r != QCNT_W'(QDEPTH));
  assign push       = push_valid && push_ready;
  assign pop        = pop_ready && (count_r != '0);

  assign head.valid = (count_r != '0);
  assign head.beat  = mem_r[rd_ptr_r];
  assign fill       = count_r;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    count_nxt = count_r + QCNT_W'(push) - QCNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_beat;
    end
  end

endmodule

/* src/ppmp6_parse.sv */
// Back end: header/pixel state machine with registered result stage.
`timescale 1ns / 1ps
module ppmp6_parse
  import ppmp6_pkg::*;
#(
  parameter int unsigned DIM_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  ppmp6_qout_t head,
  output logic        pop_ready,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_kind,
  output logic [15:0] out_image_cols,
  output logic [15:0] out_image_rows,
  output logic [7:0]  out_red,
  output logic [7:0]  out_green,
  output logic [7:0]  out_blue,
  output logic [1:0]  out_fault,
  output logic        out_last_pixel
);

  localparam int unsigned PIX_W = 2 * DIM_BITS;

  typedef enum logic [9:0] {
    PH_MAGIC0 = 10'b00_0000_0001,
    PH_MAGIC1 = 10'b00_0000_0010,
    PH_GAP_W  = 10'b00_0000_0100,
    PH_NUM_W  = 10'b00_0000_1000,
    PH_GAP_H  = 10'b00_0001_0000,
    PH_NUM_H  = 10'b00_0010_0000,
    PH_GAP_M  = 10'b00_0100_0000,
    PH_NUM_M  = 10'b00_1000_0000,
    PH_PIXELS = 10'b01_0000_0000,
    PH_ERROR  = 10'b10_0000_0000
  } ppmp6_phase_t;

  ppmp6_phase_t         phase_r, phase_nxt;
  logic                 comment_r, comment_nxt;
  logic [15:0]          accum_r, accum_nxt;
  logic [DIM_BITS-1:0]  width_r, width_nxt;
  logic [DIM_BITS-1:0]  height_r, height_nxt;
  logic [PIX_W-1:0]     pix_left_r, pix_left_nxt;
  logic [1:0]           byte_idx_r, byte_idx_nxt;
  logic [7:0]           red_r, red_nxt;
  logic [7:0]           green_r, green_nxt;

  logic                 out_valid_r, out_valid_nxt;
  logic [1:0]           kind_r, fault_r;
  logic [15:0]          cols_r, rows_r;
  logic [7:0]           ored_r, ogreen_r, oblue_r;
  logic                 last_r;

  logic                 consume;
  ppmp6_beat_t          b;
  logic [19:0]          acc_mul;
  logic                 dim_ovf, max_ovf;
  logic [PIX_W-1:0]     area;
  logic [PIX_W-1:0]     pix_dec;

  logic                 res_valid;
  logic [1:0]           res_kind, res_fault;
  logic [15:0]          res_cols, res_rows;
  logic [7:0]           res_red, res_green, res_blue;
  logic                 res_last;

  assign pop_ready = !out_valid_r || out_ready;
  assign consume   = head.valid && pop_ready;
  assign b         = head.beat;

  // accum * 10 + digit
  assign acc_mul = ({4'b0, accum_r} << 3) + ({4'b0, accum_r} << 1) + {16'b0, b.digit};
  assign dim_ovf = |acc_mul[19:DIM_BITS];
  assign max_ovf = |acc_mul[19:16];
  assign area    = width_r * height_r;
  assign pix_dec = pix_left_r - PIX_W'(pix_left_r != '0);

  always_comb begin
    phase_nxt    = phase_r;
    comment_nxt  = comment_r;
    accum_nxt    = accum_r;
    width_nxt    = width_r;
    height_nxt   = height_r;
    pix_left_nxt = pix_left_r;
    byte_idx_nxt = byte_idx_r;
    red_nxt      = red_r;
    green_nxt    = green_r;
    res_valid    = 1'b0;
    res_kind     = KIND_HEADER;
    res_fault    = FAULT_MAGIC;
    res_cols     = '0;
    res_rows     = '0;
    res_red      = '0;
    res_green    = '0;
    res_blue     = '0;
    res_last     = 1'b0;

    unique case (phase_r)
      PH_MAGIC0: begin
        if (!b.is_ws) begin
          if (b.is_p) begin
            phase_nxt = PH_MAGIC1;
          end else begin
            phase_nxt = PH_ERROR;
            res_valid = 1'b1;
            res_kind  = KIND_ERROR;
            res_fault = FAULT_MAGIC;
          end
        end
      end
      PH_MAGIC1: begin
        if (b.is_six) begin
          phase_nxt   = PH_GAP_W;
          comment_nxt = 1'b0;
        end else begin
          phase_nxt = PH_ERROR;
          res_valid = 1'b1;
          res_kind  = KIND_ERROR;
          res_fault = FAULT_MAGIC;
        end
      end
      PH_GAP_W, PH_GAP_H, PH_GAP_M: begin
        priority if (comment_r) begin
          if (b.is_eol) begin
            comment_nxt = 1'b0;
          end
        end else if (b.is_ws) begin
          comment_nxt = 1'b0;
        end else if (b.is_hash) begin
          comment_nxt = 1'b1;
        end else if (b.is_digit) begin
          accum_nxt = {12'b0, b.digit};
          phase_nxt = (phase_r == PH_GAP_W) ? PH_NUM_W :
                      (phase_r == PH_GAP_H) ? PH_NUM_H : PH_NUM_M;
        end else begin
          phase_nxt = PH_ERROR;
          res_valid = 1'b1;
          res_kind  = KIND_ERROR;
          res_fault = FAULT_NONDIGIT;
        end
      end
      PH_NUM_W, PH_NUM_H: begin
        priority if (b.is_digit) begin
          if (dim_ovf) begin
            phase_nxt = PH_ERROR;
            res_valid = 1'b1;
            res_kind  = KIND_ERROR;
            res_fault = FAULT_OVERFLOW;
          end else begin
            accum_nxt = acc_mul[15:0];
          end
        end else if (b.is_ws || b.is_hash) begin
          if (phase_r == PH_NUM_W) begin
            width_nxt = accum_r[DIM_BITS-1:0];
            phase_nxt = PH_GAP_H;
          end else begin
            height_nxt = accum_r[DIM_BITS-1:0];
            phase_nxt  = PH_GAP_M;
          end
          accum_nxt   = '0;
          comment_nxt = b.is_hash;
        end else begin
          phase_nxt = PH_ERROR;
          res_valid = 1'b1;
          res_kind  = KIND_ERROR;
          res_fault = FAULT_NONDIGIT;
        end
      end
      PH_NUM_M: begin
        priority if (b.is_digit) begin
          if (max_ovf) begin
            phase_nxt = PH_ERROR;
            res_valid = 1'b1;
            res_kind  = KIND_ERROR;
            res_fault = FAULT_OVERFLOW;
          end else begin
            accum_nxt = acc_mul[15:0];
          end
        end else if (b.is_ws) begin
          res_valid = 1'b1;
          if (accum_r != MAXVAL_REQ) begin
            phase_nxt = PH_ERROR;
            res_kind  = KIND_ERROR;
            res_fault = FAULT_MAXVAL;
          end else begin
            accum_nxt    = '0;
            pix_left_nxt = area;
            byte_idx_nxt = '0;
            phase_nxt    = ((width_r == '0) || (height_r == '0)) ? PH_MAGIC0 : PH_PIXELS;
            res_kind     = KIND_HEADER;
            res_cols     = 16'(width_r);
            res_rows     = 16'(height_r);
          end
        end else begin
          phase_nxt = PH_ERROR;
          res_valid = 1'b1;
          res_kind  = KIND_ERROR;
          res_fault = FAULT_NONDIGIT;
        end
      end
      PH_PIXELS: begin
        priority if (byte_idx_r == 2'd0) begin
          red_nxt      = b.data;
          byte_idx_nxt = 2'd1;
        end else if (byte_idx_r == 2'd1) begin
          green_nxt    = b.data;
          byte_idx_nxt = 2'd2;
        end else begin
          byte_idx_nxt = 2'd0;
          pix_left_nxt = pix_dec;
          res_valid    = 1'b1;
          res_kind     = KIND_PIXEL;
          res_red      = red_r;
          res_green    = green_r;
          res_blue     = b.data;
          if (pix_dec == '0) begin
            res_last  = 1'b1;
            phase_nxt = PH_MAGIC0;
          end
        end
      end
      PH_ERROR: begin
        phase_nxt = PH_ERROR;
      end
      default: begin
        phase_nxt = PH_ERROR;
      end
    endcase

    out_valid_nxt = out_valid_r && !out_ready;
    if (consume && res_valid) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_MAGIC0;
      comment_r   <= 1'b0;
      accum_r     <= '0;
      width_r     <= '0;
      height_r    <= '0;
      pix_left_r  <= '0;
      byte_idx_r  <= '0;
      red_r       <= '0;
      green_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (consume) begin
        phase_r    <= phase_nxt;
        comment_r  <= comment_nxt;
        accum_r    <= accum_nxt;
        width_r    <= width_nxt;
        height_r   <= height_nxt;
        pix_left_r <= pix_left_nxt;
        byte_idx_r <= byte_idx_nxt;
        red_r      <= red_nxt;
        green_r    <= green_nxt;
      end
      out_valid_r <= out_valid_nxt;
    end
  end

  // result payload, loaded only when a new result is produced
  always_ff @(posedge clk) begin
    if (consume && res_valid) begin
      kind_r   <= res_kind;
      fault_r  <= res_fault;
      cols_r   <= res_cols;
      rows_r   <= res_rows;
      ored_r   <= res_red;
      ogreen_r <= res_green;
      oblue_r  <= res_blue;
      last_r   <= res_last;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_kind       = kind_r;
  assign out_fault      = fault_r;
  assign out_image_cols = cols_r;
  assign out_image_rows = rows_r;
  assign out_red        = ored_r;
  assign out_green      = ogreen_r;
  assign out_blue       = oblue_r;
  assign out_last_pixel = last_r;

endmodule

/* src/ppm_p6_stream_parser_core.sv */
// Top level of the PPM P6 stream parser: classifier, queue and parser.
`timescale 1ns / 1ps
// Usage
//   Input channel (in_valid/in_ready/in_data_byte): one byte of a binary PPM
//   file per beat. The header is "P6" or "p6", then width, height and maxval
//   in decimal, separated by whitespace and '#' comments; maxval must be 255.
//   One whitespace byte ends the header, then width*height RGB triples follow.
//   Result channel (out_valid/out_ready/out_*): zero or one beat per input
//   byte - a header beat (kind 0, cols/rows), a pixel beat per triple (kind 1,
//   last_pixel on the final one) or an error beat (kind 2, fault code).
//   Unused result fields read as zero.
//   After the last pixel (or an empty image) the parser waits for a new file.
//   After an error it swallows every byte until reset.
// Timing
//   One byte per clock sustained while out_ready stays high. A byte enters a
//   two-entry queue; the parser takes it from the head and loads the output
//   register, which drives out_valid.
//   While the output register is stalled the parser holds and the queue
//   fills; in_ready drops once both queue entries are occupied.
// Reset
//   rst_n is synchronous, active low: queue empty, no result pending, parser
//   waiting for the magic number.
module ppm_p6_stream_parser_core
  import ppmp6_pkg::*;
#(
  parameter int unsigned DIM_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_data_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_kind,
  output logic [15:0] out_image_cols,
  output logic [15:0] out_image_rows,
  output logic [7:0]  out_red,
  output logic [7:0]  out_green,
  output logic [7:0]  out_blue,
  output logic [1:0]  out_fault,
  output logic        out_last_pixel
);

  ppmp6_beat_t       cls_beat;
  ppmp6_qout_t       q_head;
  logic              q_pop;
  logic [QCNT_W-1:0] q_fill;

  // front end: byte classification
  ppmp6_front u_front (
    .in_data_byte (in_data_byte),
    .beat         (cls_beat)
  );

  // decoupling queue, lets input keep flowing while the result side stalls
  ppmp6_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (in_valid),
    .push_ready (in_ready),
    .push_beat  (cls_beat),
    .head       (q_head),
    .pop_ready  (q_pop),
    .fill       (q_fill)
  );

  // back end: header and pixel parsing, registered result
  ppmp6_parse #(
    .DIM_BITS (DIM_BITS)
  ) u_parse (
    .clk            (clk),
    .rst_n          (rst_n),
    .head           (q_head),
    .pop_ready      (q_pop),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_kind       (out_kind),
    .out_image_cols (out_image_cols),
    .out_image_rows (out_image_rows),
    .out_red        (out_red),
    .out_green      (out_green),
    .out_blue       (out_blue),
    .out_fault      (out_fault),
    .out_last_pixel (out_last_pixel)
  );

  // queue never holds more than its depth
  a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
    q_fill <= QCNT_W'(QDEPTH))
    else $error("queue fill beyond depth");

  // queue drains whenever the result register is free
  a_drain: assert property (@(posedge clk) disable iff (!rst_n)
    (q_fill != '0) && !out_valid |-> q_pop)
    else $error("parser stalled with free result register");

  // last pixel flag only on pixel beats
  a_last_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last_pixel |-> out_kind == KIND_PIXEL)
    else $error("last_pixel on non-pixel result");

  // non-zero fault code only on error beats
  a_fault_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_fault != FAULT_MAGIC) |-> out_kind == KIND_ERROR)
    else $error("fault code on non-error result");

endmodule

/* bench/ppm_p6_stream_parser_checker.sv */
// Scoreboard for the PPM P6 stream parser: predicts result beats and compares them.
`timescale 1ns / 1ps
module ppm_p6_stream_parser_checker
  import ppmp6_pkg::*;
#(
  parameter int unsigned DIM_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [7:0]  in_data_byte,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [1:0]  out_kind,
  input  logic [15:0] out_image_cols,
  input  logic [15:0] out_image_rows,
  input  logic [7:0]  out_red,
  input  logic [7:0]  out_green,
  input  logic [7:0]  out_blue,
  input  logic [1:0]  out_fault,
  input  logic        out_last_pixel,
  output int unsigned mismatch_count,
  output int unsigned results_pending
);

  typedef enum logic [9:0] {
    AWAIT_P    = 10'b00_0000_0001,
    AWAIT_SIX  = 10'b00_0000_0010,
    GAP_COLS   = 10'b00_0000_0100,
    NUM_COLS   = 10'b00_0000_1000,
    GAP_ROWS   = 10'b00_0001_0000,
    NUM_ROWS   = 10'b00_0010_0000,
    GAP_MAX    = 10'b00_0100_0000,
    NUM_MAX    = 10'b00_1000_0000,
    PIXEL_DATA = 10'b01_0000_0000,
    HALTED     = 10'b10_0000_0000
  } parse_phase_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] cols;
    logic [15:0] rows;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [1:0]  fault;
    logic        last_pixel;
  } parser_result_t;

  localparam logic [7:0]  CH_LF    = 8'h0A;
  localparam logic [7:0]  CH_CR    = 8'h0D;
  localparam logic [7:0]  CH_SPACE = 8'h20;
  localparam logic [7:0]  CH_HASH  = 8'h23;
  localparam logic [7:0]  CH_ZERO  = 8'h30;
  localparam logic [7:0]  CH_NINE  = 8'h39;
  localparam logic [7:0]  CH_SIX   = 8'h36;
  localparam logic [7:0]  CH_P_UP  = 8'h50;
  localparam logic [7:0]  CH_P_LO  = 8'h70;
  localparam logic [31:0] DIM_LIMIT    = (32'd1 << DIM_BITS) - 32'd1;
  localparam logic [31:0] MAXVAL_LIMIT = 32'd65535;

  parse_phase_t   phase;
  logic           in_comment;
  logic [31:0]    accum;
  logic [31:0]    cols_value;
  logic [31:0]    rows_value;
  logic [31:0]    pixels_left;
  logic [1:0]     byte_in_pixel;
  logic [7:0]     held_red;
  logic [7:0]     held_green;
  parser_result_t pending_results[$];
  int unsigned    mismatches = 0;

  assign mismatch_count = mismatches;

  function automatic bit is_blank(input logic [7:0] b);
    return b == CH_SPACE || (b >= 8'h09 && b <= CH_CR);
  endfunction

  function automatic bit is_numeral(input logic [7:0] b);
    return b >= CH_ZERO && b <= CH_NINE;
  endfunction

  function automatic bit raise_fault(inout parser_result_t r, input logic [1:0] code);
    r.kind  = KIND_ERROR;
    r.fault = code;
    phase   = HALTED;
    return 1'b1;
  endfunction

  // Whitespace and comments between header tokens, or the first digit of the next one.
  function automatic bit gap_step(input logic [7:0] b, input parse_phase_t next_phase,
                                  inout parser_result_t r);
    gap_step = 1'b0;
    if (in_comment) begin
      if (b == CH_LF || b == CH_CR) in_comment = 1'b0;
    end else if (b == CH_HASH) begin
      in_comment = 1'b1;
    end else if (is_numeral(b)) begin
      accum = {28'd0, b[3:0]};
      phase = next_phase;
    end else if (!is_blank(b)) begin
      gap_step = raise_fault(r, FAULT_NONDIGIT);
    end
  endfunction

  // Advances the parser by one byte; returns 1 when the byte yields a result beat.
  function automatic bit parse_byte(input logic [7:0] b, output parser_result_t r);
    logic [31:0] grown;
    logic [31:0] limit;
    r = '0;
    parse_byte = 1'b0;
    grown = accum * 32'd10 + {28'd0, b[3:0]};
    limit = (phase == NUM_MAX) ? MAXVAL_LIMIT : DIM_LIMIT;
    case (phase)
      AWAIT_P: begin
        if (b == CH_P_UP || b == CH_P_LO) phase = AWAIT_SIX;
        else if (!is_blank(b)) parse_byte = raise_fault(r, FAULT_MAGIC);
      end
      AWAIT_SIX: begin
        if (b == CH_SIX) begin
          phase = GAP_COLS;
          in_comment = 1'b0;
        end else begin
          parse_byte = raise_fault(r, FAULT_MAGIC);
        end
      end
      GAP_COLS: parse_byte = gap_step(b, NUM_COLS, r);
      GAP_ROWS: parse_byte = gap_step(b, NUM_ROWS, r);
      GAP_MAX:  parse_byte = gap_step(b, NUM_MAX, r);
      NUM_COLS, NUM_ROWS, NUM_MAX: begin
        if (is_numeral(b)) begin
          if (grown > limit) parse_byte = raise_fault(r, FAULT_OVERFLOW);
          else accum = grown;
        end else if (phase == NUM_MAX) begin
          if (!is_blank(b)) begin
            parse_byte = raise_fault(r, FAULT_NONDIGIT);
          end else if (accum != {16'd0, MAXVAL_REQ}) begin
            parse_byte = raise_fault(r, FAULT_MAXVAL);
          end else begin
            accum = '0;
            pixels_left = cols_value * rows_value;
            byte_in_pixel = 2'd0;
            if (pixels_left == 0) phase = AWAIT_P;
            else phase = PIXEL_DATA;
            r.kind = KIND_HEADER;
            r.cols = cols_value[15:0];
            r.rows = rows_value[15:0];
            parse_byte = 1'b1;
          end
        end else if (is_blank(b) || b == CH_HASH) begin
          if (phase == NUM_COLS) begin
            cols_value = accum;
            phase = GAP_ROWS;
          end else begin
            rows_value = accum;
            phase = GAP_MAX;
          end
          accum = '0;
          in_comment = (b == CH_HASH);
        end else begin
          parse_byte = raise_fault(r, FAULT_NONDIGIT);
        end
      end
      PIXEL_DATA: begin
        case (byte_in_pixel)
          2'd0: begin
            held_red = b;
            byte_in_pixel = 2'd1;
          end
          2'd1: begin
            held_green = b;
            byte_in_pixel = 2'd2;
          end
          default: begin
            byte_in_pixel = 2'd0;
            if (pixels_left != 0) pixels_left = pixels_left - 32'd1;
            r.kind  = KIND_PIXEL;
            r.red   = held_red;
            r.green = held_green;
            r.blue  = b;
            if (pixels_left == 0) begin
              r.last_pixel = 1'b1;
              phase = AWAIT_P;
            end
            parse_byte = 1'b1;
          end
        endcase
      end
      default: ;
    endcase
  endfunction

  task automatic compare_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin : watch
    parser_result_t fresh;
    parser_result_t want;
    if (!rst_n) begin
      phase         = AWAIT_P;
      in_comment    = 1'b0;
      accum         = '0;
      cols_value    = '0;
      rows_value    = '0;
      pixels_left   = '0;
      byte_in_pixel = 2'd0;
      held_red      = '0;
      held_green    = '0;
      pending_results.delete();
      results_pending <= 0;
    end else begin
      if (out_valid && out_ready) begin
        if (pending_results.size() == 0) begin
          $error("result beat with nothing predicted, kind %0d", out_kind);
          mismatches++;
        end else begin
          want = pending_results.pop_front();
          compare_field("kind", 16'(want.kind), 16'(out_kind));
          compare_field("image_cols", want.cols, out_image_cols);
          compare_field("image_rows", want.rows, out_image_rows);
          compare_field("red", 16'(want.red), 16'(out_red));
          compare_field("green", 16'(want.green), 16'(out_green));
          compare_field("blue", 16'(want.blue), 16'(out_blue));
          compare_field("fault", 16'(want.fault), 16'(out_fault));
          compare_field("last_pixel", 16'(want.last_pixel), 16'(out_last_pixel));
        end
      end
      if (in_valid && in_ready) begin
        if (parse_byte(in_data_byte, fresh)) pending_results.push_back(fresh);
      end
      results_pending <= pending_results.size();
    end
  end

endmodule

/* bench/ppm_p6_stream_parser_core_test.sv */
// Top of the PPM P6 parser testbench: clock, reset, byte stimulus, result sink, verdict.
`timescale 1ns / 1ps
module ppm_p6_stream_parser_core_test
  import ppmp6_pkg::*;
();

  localparam int unsigned DIM_BITS     = 16;
  localparam int unsigned RANDOM_BYTES = 360;  // rough size of the random part
  localparam int unsigned HOLD_CYCLES  = 80;   // long sink stall, well past queue depth
  localparam int unsigned STALL_LIMIT  = 2000; // cycles with no beat before giving up

  localparam logic [7:0] CH_VT    = 8'h0B;
  localparam logic [7:0] CH_FF    = 8'h0C;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_SIX   = 8'h36;
  localparam logic [7:0] CH_P_UP  = 8'h50;
  localparam logic [7:0] CH_P_LO  = 8'h70;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [7:0]  in_data_byte;
  logic        out_valid;
  logic        out_ready;
  logic [1:0]  out_kind;
  logic [15:0] out_image_cols;
  logic [15:0] out_image_rows;
  logic [7:0]  out_red;
  logic [7:0]  out_green;
  logic [7:0]  out_blue;
  logic [1:0]  out_fault;
  logic        out_last_pixel;

  int unsigned mismatch_count;
  int unsigned results_pending;
  int unsigned bytes_sent   = 0;
  int unsigned holds_asked  = 0;  // bumped by the source, served by the sink
  int unsigned holds_served = 0;
  int unsigned idle_cycles  = 0;
  bit          no_idle      = 1'b0; // both sides run flat out while set

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  ppm_p6_stream_parser_core #(.DIM_BITS(DIM_BITS)) dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_data_byte   (in_data_byte),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_kind       (out_kind),
    .out_image_cols (out_image_cols),
    .out_image_rows (out_image_rows),
    .out_red        (out_red),
    .out_green      (out_green),
    .out_blue       (out_blue),
    .out_fault      (out_fault),
    .out_last_pixel (out_last_pixel)
  );

  ppm_p6_stream_parser_checker #(.DIM_BITS(DIM_BITS)) u_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_data_byte    (in_data_byte),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_kind        (out_kind),
    .out_image_cols  (out_image_cols),
    .out_image_rows  (out_image_rows),
    .out_red         (out_red),
    .out_green       (out_green),
    .out_blue        (out_blue),
    .out_fault       (out_fault),
    .out_last_pixel  (out_last_pixel),
    .mismatch_count  (mismatch_count),
    .results_pending (results_pending)
  );

  // Watchdog: a lost result or a wedged handshake shows up as a long run of
  // cycles in which neither channel moves a beat.
  always @(posedge clk) begin
    if (!rst_n) begin
      idle_cycles <= 0;
    end else if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Mostly back to back, some short gaps, the odd long one.
  function automatic int unsigned pick_gap();
    int unsigned roll;
    if (no_idle) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 65) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic bit is_blank(input logic [7:0] b);
    return b == CH_SPACE || (b >= 8'h09 && b <= CH_CR);
  endfunction

  // A byte that can never be part of a token or a gap.
  function automatic logic [7:0] pick_stray();
    logic [7:0] b;
    do b = 8'($urandom_range(0, 255));
    while (is_blank(b) || b == CH_HASH || (b >= CH_ZERO && b <= CH_NINE));
    return b;
  endfunction

  // Result sink: random ready pattern, plus a long hold-off whenever the
  // source asks for one, so the queue fills and in_ready drops.
  initial begin
    int unsigned gap;
    out_ready <= 1'b0;
    repeat (10) @(posedge clk);
    forever begin
      if (holds_served != holds_asked) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        holds_served++;
      end else begin
        gap = pick_gap();
        if (gap > 0) begin
          out_ready <= 1'b0;
          repeat (gap) @(posedge clk);
        end
        out_ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  // One byte beat; valid stays up until the edge that takes it.
  task automatic send_byte(input logic [7:0] b);
    int unsigned gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_data_byte <= b;
    do @(posedge clk); while (!in_ready);
    bytes_sent++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i]);
  endtask

  task automatic send_ws();
    int unsigned k;
    k = $urandom_range(0, 5);
    send_byte((k == 5) ? CH_SPACE : 8'h09 + k[7:0]);
  endtask

  // '#' comment with arbitrary body, closed by LF or CR.
  task automatic send_comment();
    logic [7:0] b;
    send_byte(CH_HASH);
    repeat ($urandom_range(0, 5)) begin
      do b = 8'($urandom_range(0, 255)); while (b == CH_LF || b == CH_CR);
      send_byte(b);
    end
    send_byte($urandom_range(0, 1) ? CH_LF : CH_CR);
  endtask

  task automatic send_gap();
    repeat ($urandom_range(0, 2)) begin
      if ($urandom_range(0, 1)) repeat ($urandom_range(1, 3)) send_ws();
      else send_comment();
    end
  endtask

  task automatic send_number(input int unsigned v);
    if ($urandom_range(0, 4) == 0) repeat ($urandom_range(1, 2)) send_byte(CH_ZERO);
    send_text($sformatf("%0d", v));
  endtask

  // Magic, three numbers with varied separators, then the single whitespace.
  task automatic send_header(input int unsigned cols, input int unsigned rows,
                             input int unsigned maxv);
    repeat ($urandom_range(0, 2)) send_ws();
    send_byte($urandom_range(0, 1) ? CH_P_UP : CH_P_LO);
    send_byte(CH_SIX);
    send_gap();
    send_number(cols);
    if ($urandom_range(0, 1)) send_ws();
    else send_comment();
    send_gap();
    send_number(rows);
    if ($urandom_range(0, 1)) send_ws();
    else send_comment();
    send_gap();
    send_number(maxv);
    send_ws();
  endtask

  task automatic send_file(input int unsigned cols, input int unsigned rows,
                           input bit with_hold);
    send_header(cols, rows, 255);
    if (with_hold) holds_asked++;
    repeat (cols * rows * 3) send_byte(8'($urandom_range(0, 255)));
  endtask

  // Source pauses until every predicted beat has come out. The extra edge lets
  // the count take in the byte accepted last.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (results_pending != 0) @(posedge clk);
  endtask

  initial begin
    int unsigned file_no;
    int unsigned cols;
    int unsigned rows;
    int unsigned maxv;
    logic [1:0]  fault_pick;
    logic [7:0]  b;
    rst_n        <= 1'b0;
    in_valid     <= 1'b0;
    in_data_byte <= 8'h00;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: widest image with no rows, comment straight after a width
    // digit, lower-case magic, comments closed by CR and by LF, every
    // whitespace kind, leading zeros, a number right after the magic, one
    // extreme pixel, and files back to back.
    send_text("\tP6 65535#\n0 255\n");
    send_text("p6#c\r00001");
    send_byte(CH_VT);
    send_text("1#\n");
    send_byte(CH_FF);
    send_text("255\r");
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(8'hA5);
    send_text("P60 65535 255 ");

    // Random well-formed files; the first one gets the long sink hold-off.
    bytes_sent = 0;
    file_no = 0;
    while (bytes_sent < RANDOM_BYTES) begin
      no_idle = ($urandom_range(0, 4) == 0);
      if (file_no == 0) begin
        send_file(6, 6, 1'b1);
      end else if ($urandom_range(0, 19) == 0) begin
        cols = $urandom_range(0, 65535);
        if ($urandom_range(0, 1)) send_file(cols, 0, 1'b0);
        else send_file(0, cols, 1'b0);
      end else begin
        cols = $urandom_range(1, 3);
        rows = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 3);
        send_file(cols, rows, 1'b0);
      end
      repeat ($urandom_range(0, 2)) send_ws();
      if (file_no % 6 == 5) drain();
      file_no++;
    end

    // An error is sticky until reset, so only one kind ends each run.
    no_idle = 1'b0;
    fault_pick = 2'($urandom_range(0, 3));
    case (fault_pick)
      FAULT_MAGIC: begin
        if ($urandom_range(0, 1)) begin
          send_byte(CH_P_UP);
          do b = 8'($urandom_range(0, 255)); while (b == CH_SIX);
          send_byte(b);
        end else begin
          do b = 8'($urandom_range(0, 255));
          while (is_blank(b) || b == CH_P_UP || b == CH_P_LO);
          send_byte(b);
        end
      end
      FAULT_MAXVAL: begin
        do maxv = $urandom_range(0, 65535); while (maxv == 255);
        send_header($urandom_range(0, 3), $urandom_range(0, 3), maxv);
      end
      FAULT_NONDIGIT: begin
        case ($urandom_range(0, 3))
          0: send_text("P6 ");
          1: send_text("p6 12");
          2: send_text("P6 3 4#z\n");
          default: send_text("P6 1 1 255#");
        endcase
        send_byte(pick_stray());
      end
      default: begin
        case ($urandom_range(0, 2))
          0: send_header($urandom_range(65536, 99999), 1, 255);
          1: send_header(1, $urandom_range(65536, 99999), 255);
          default: send_header(1, 1, $urandom_range(65536, 99999));
        endcase
      end
    endcase
    // Everything after the error must be swallowed silently.
    repeat (16) send_byte(8'($urandom_range(0, 255)));

    drain();
    repeat (8) @(posedge clk);
    if (mismatch_count == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

endmodule

/* filelist.f */
src/ppmp6_pkg.sv
src/ppmp6_front.sv
src/ppmp6_queue.sv
src/ppmp6_parse.sv
src/ppm_p6_stream_parser_core.sv
bench/ppm_p6_stream_parser_checker.sv
bench/ppm_p6_stream_parser_core_test.sv
